// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sieve factoriser RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define SPF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen outside reset
`define SPF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SPF_ASSERT(lbl, clk, rstn, prop, msg)
`define SPF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/core/spf_pkg.sv -----
// Shared types and constants of the sieve factoriser.
// Used by the controller, the datapath, the divider and the top level.
package spf_pkg;

  localparam int VAL_W = 16;
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] MAX_FACTORS = 3'd6;
  localparam logic [VAL_W-1:0] MIN_LIMIT   = 16'd2;
  localparam logic [VAL_W-1:0] RESET_LIMIT = 16'd65535;
  localparam logic [VAL_W-1:0] RESET_ABOVE = 16'd3;

  // Item kinds
  localparam logic KIND_BUILD  = 1'b0;
  localparam logic KIND_FACTOR = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SIEVE_LIMIT  = 1'b0;
  localparam logic CFG_REPORT_ABOVE = 1'b1;

  typedef enum logic [1:0] {
    ADDR_X = 2'd0,
    ADDR_Y = 2'd1,
    ADDR_V = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      start_build;
    logic      clr_wr;
    logic      x_init;
    logic      x_inc;
    logic      mark_prime;
    logic      sq_load;
    logic      y_init;
    logic      stamp;
    addr_sel_t addr_sel;
    logic      finish_build;
    logic      p_load;
    logic      found_take;
    logic      first_set;
    logic      div_start;
    logic      div_take;
    logic      push_mid;
    logic      push_final;
    logic      push_err;
    logic      push_done;
  } spf_cmd_t;

  typedef struct packed {
    logic kind_build;
    logic err_cond;
    logic x_last;
    logic rdata_zero;
    logic sq_le_lim;
    logic y_next_gt;
    logic v_gt1;
    logic p_report;
    logic pend_valid;
    logic div_done;
    logic div_take_ok;
    logic q_gt1;
    logic out_free;
  } spf_stat_t;

endpackage

// ----- rtl/core/spf_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module spf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/spf_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on spf_pkg for the value width.
module spf_div import spf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quot,
  output logic [VAL_W-1:0] rem
);

  localparam int SW = $clog2(VAL_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(VAL_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SW-1:0]    step_r;
  logic [VAL_W-1:0] rem_r, quo_r, dvs_r;
  logic [VAL_W:0]   shifted, diff;
  logic             fits;

  // One trial subtraction
  assign shifted = {rem_r, quo_r[VAL_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && step_r == LAST_STEP) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Shift in one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
      quo_r  <= {quo_r[VAL_W-2:0], fits};
      step_r <= step_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/spf_dp.sv -----
// Datapath: configuration, table RAM, sieve counters, divider and result register.
// Depends on spf_pkg, spf_ram and spf_div.
module spf_dp import spf_pkg::*; #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spf_cmd_t         cmd,
  output spf_stat_t        stat,
  input  logic             in_kind,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_prime,
  output logic             out_has_prime,
  output logic             out_last,
  output logic             out_error
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [31:0] MAX_IDX = 32'(TABLE_DEPTH - 1);

  logic [VAL_W-1:0] sieve_limit_r, report_above_r, built_limit_r;
  logic             ready_r;
  logic             kind_r;
  logic [VAL_W-1:0] v_r, lim_r, p_r, pend_r;
  logic             pend_valid_r, first_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VAL_W:0]   x_r, y_r, y_sum;
  logic [31:0]      sq_r;
  logic [VAL_W-1:0] sat_lim;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_prime_r;
  logic             out_has_r, out_last_r, out_err_r;
  logic             push;

  logic [AW-1:0]    ram_addr;
  logic             ram_we;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic             div_done;
  logic [VAL_W-1:0] div_quot, div_rem;

  // Saturate the requested limit into the table
  always_comb begin
    sat_lim = sieve_limit_r;
    if (sieve_limit_r < MIN_LIMIT) begin
      sat_lim = MIN_LIMIT;
    end else if ({16'd0, sieve_limit_r} > MAX_IDX) begin
      sat_lim = MAX_IDX[VAL_W-1:0];
    end
  end

  assign y_sum = y_r + x_r;

  // Status to the controller
  always_comb begin
    stat.kind_build  = (kind_r == KIND_BUILD);
    stat.err_cond    = !ready_r || (v_r > built_limit_r);
    stat.x_last      = (x_r >= {1'b0, lim_r});
    stat.rdata_zero  = (ram_rdata == '0);
    stat.sq_le_lim   = (sq_r <= {16'd0, lim_r});
    stat.y_next_gt   = (y_sum > {1'b0, lim_r});
    stat.v_gt1       = (v_r > 16'd1);
    stat.p_report    = (p_r > report_above_r) && (cnt_r < MAX_FACTORS);
    stat.pend_valid  = pend_valid_r;
    stat.div_done    = div_done;
    stat.div_take_ok = first_r || (div_rem == '0);
    stat.q_gt1       = (div_quot > 16'd1);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // Table port selection
  always_comb begin
    case (cmd.addr_sel)
      ADDR_X:  ram_addr = AW'(x_r[VAL_W-1:0]);
      ADDR_Y:  ram_addr = AW'(y_r[VAL_W-1:0]);
      ADDR_V:  ram_addr = AW'(v_r);
      default: ram_addr = AW'(x_r[VAL_W-1:0]);
    endcase
  end

  assign ram_we    = cmd.clr_wr || cmd.mark_prime || (cmd.stamp && stat.rdata_zero);
  assign ram_wdata = cmd.clr_wr ? '0 : x_r[VAL_W-1:0];

  spf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  spf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (v_r),
    .divisor  (p_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Configuration and table status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sieve_limit_r  <= RESET_LIMIT;
      report_above_r <= RESET_ABOVE;
      ready_r        <= 1'b0;
      built_limit_r  <= '0;
      pend_valid_r   <= 1'b0;
      first_r        <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_SIEVE_LIMIT) begin
        sieve_limit_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_REPORT_ABOVE) begin
        report_above_r <= cfg_data;
      end
      if (cmd.finish_build) begin
        ready_r       <= 1'b1;
        built_limit_r <= lim_r;
      end
      if (cmd.load_item) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.found_take) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.first_set) begin
        first_r <= 1'b1;
      end else if (cmd.div_take) begin
        first_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      v_r    <= in_value;
      cnt_r  <= '0;
    end else if (cmd.div_take) begin
      v_r <= div_quot;
    end
    if (cmd.start_build) begin
      lim_r <= sat_lim;
    end
    if (cmd.start_build || cmd.x_init) begin
      x_r <= 17'd2;
    end else if (cmd.clr_wr || cmd.x_inc) begin
      x_r <= x_r + 1'b1;
    end
    if (cmd.sq_load) begin
      sq_r <= 32'(x_r[VAL_W-1:0]) * 32'(x_r[VAL_W-1:0]);
    end
    if (cmd.y_init) begin
      y_r <= sq_r[VAL_W:0];
    end else if (cmd.stamp) begin
      y_r <= y_sum;
    end
    if (cmd.p_load) begin
      p_r <= (ram_rdata < 16'd2) ? v_r : ram_rdata;
    end
    if (cmd.found_take) begin
      pend_r <= p_r;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // Result register: load on push, drop once taken
  assign push = cmd.push_mid || cmd.push_final || cmd.push_err || cmd.push_done;

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_mid) begin
      out_prime_r <= pend_r;
      out_has_r   <= 1'b1;
      out_last_r  <= 1'b0;
      out_err_r   <= 1'b0;
    end else if (cmd.push_final) begin
      out_prime_r <= pend_valid_r ? pend_r : '0;
      out_has_r   <= pend_valid_r;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b0;
    end else if (cmd.push_err || cmd.push_done) begin
      out_prime_r <= '0;
      out_has_r   <= 1'b0;
      out_last_r  <= 1'b1;
      out_err_r   <= cmd.push_err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_prime     = out_prime_r;
  assign out_has_prime = out_has_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

endmodule

// ----- rtl/core/spf_ctrl.sv -----
// Controller state machine: sequences table builds and factor walks.
// Depends on spf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spf_ctrl import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  spf_stat_t stat,
  output spf_cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_DISP     = 17'h00002,
    S_CLR      = 17'h00004,
    S_SCAN_RD  = 17'h00008,
    S_SCAN_CHK = 17'h00010,
    S_SQ       = 17'h00020,
    S_ST_RD    = 17'h00040,
    S_ST_WR    = 17'h00080,
    S_FIN      = 17'h00100,
    S_FCHK     = 17'h00200,
    S_LK_RD    = 17'h00400,
    S_LK       = 17'h00800,
    S_FOUND    = 17'h01000,
    S_DIV_GO   = 17'h02000,
    S_DIV_WAIT = 17'h04000,
    S_FINAL    = 17'h08000,
    S_ERR      = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.kind_build) begin
          cmd.start_build = 1'b1;
          state_nxt       = S_CLR;
        end else if (stat.err_cond) begin
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      // Clear entries two to the limit
      S_CLR: begin
        cmd.clr_wr   = 1'b1;
        cmd.addr_sel = ADDR_X;
        if (stat.x_last) begin
          cmd.x_init = 1'b1;
          state_nxt  = S_SCAN_RD;
        end else begin
          cmd.x_inc = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd.addr_sel = ADDR_X;
        state_nxt    = S_SCAN_CHK;
      end
      // Unmarked entry is a prime: mark it, then stamp from its square
      S_SCAN_CHK: begin
        cmd.addr_sel = ADDR_X;
        if (stat.rdata_zero) begin
          cmd.mark_prime = 1'b1;
          cmd.sq_load    = 1'b1;
          state_nxt      = S_SQ;
        end else if (stat.x_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.x_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SQ: begin
        if (stat.sq_le_lim) begin
          cmd.y_init = 1'b1;
          state_nxt  = S_ST_RD;
        end else if (stat.x_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.x_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_ST_RD: begin
        cmd.addr_sel = ADDR_Y;
        state_nxt    = S_ST_WR;
      end
      S_ST_WR: begin
        cmd.addr_sel = ADDR_Y;
        cmd.stamp    = 1'b1;
        if (!stat.y_next_gt) begin
          state_nxt = S_ST_RD;
        end else if (stat.x_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.x_inc = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FIN: begin
        cmd.finish_build = 1'b1;
        if (stat.out_free) begin
          cmd.push_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // Factor walk
      S_FCHK: begin
        state_nxt = stat.v_gt1 ? S_LK_RD : S_FINAL;
      end
      S_LK_RD: begin
        cmd.addr_sel = ADDR_V;
        state_nxt    = S_LK;
      end
      S_LK: begin
        cmd.p_load = 1'b1;
        state_nxt  = S_FOUND;
      end
      // Hold a reported prime until the next one shows whether it is last
      S_FOUND: begin
        if (!stat.p_report) begin
          cmd.first_set = 1'b1;
          state_nxt     = S_DIV_GO;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.push_mid   = stat.pend_valid;
          cmd.found_take = 1'b1;
          cmd.first_set  = 1'b1;
          state_nxt      = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          if (stat.div_take_ok) begin
            cmd.div_take = 1'b1;
            state_nxt    = stat.q_gt1 ? S_DIV_GO : S_FCHK;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.push_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.push_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SPF_ASSERT(a_state_onehot, clk, rst_n, $onehot(state_r), "state register not one-hot")
  `SPF_ASSERT(a_push_room, clk, rst_n, (cmd.push_mid || cmd.push_final || cmd.push_err || cmd.push_done) |-> stat.out_free, "result pushed into a full output register")
  `SPF_ASSERT(a_take_stalls, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "second item taken while busy")
  `SPF_ASSERT_NEVER(a_div_stray, clk, rst_n, stat.div_done && (state_r != S_DIV_WAIT), "divider finished outside its wait state")

endmodule

// ----- rtl/core/spf_sieve_factorizer_core.sv -----
// Top level of the smallest-prime-factor sieve and factoriser.
// Depends on spf_pkg, spf_ctrl and spf_dp.
//
// One item at a time. A build item clears table entries two to the limit, then
// scans every entry with a read and a check, adding a read and a write per
// multiple stamped and a squaring step per prime found; all of it goes through
// the single port of the table RAM. A factor item needs a table lookup per
// prime factor and divisions by that prime in the bit-serial divider. The input
// stalls while an item is in work; one output register lets the next item
// start while its last result still waits.
module spf_sieve_factorizer_core import spf_pkg::*; #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_prime,
  output logic             out_has_prime,
  output logic             out_last,
  output logic             out_error
);

  spf_cmd_t  cmd;
  spf_stat_t stat;

  spf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_prime     (out_prime),
    .out_has_prime (out_has_prime),
    .out_last      (out_last),
    .out_error     (out_error)
  );

endmodule

// ----- dv/tb_spf_sieve_factorizer_core.sv -----
// Self-checking testbench of spf_sieve_factorizer_core: table builds and factor queries.
// Depends on spf_pkg and the core RTL; it predicts every result with its own sieve.
`timescale 1ns / 100ps

module tb_spf_sieve_factorizer_core import spf_pkg::*; ();

  localparam int STUCK_LIMIT = 3000000;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
  } query_t;

  typedef struct packed {
    logic [VAL_W-1:0] prime;
    logic             has_prime;
    logic             last;
    logic             error;
  } factor_res_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_kind;
  logic [VAL_W-1:0] in_value;
  logic             cfg_we;
  logic             cfg_index;
  logic [VAL_W-1:0] cfg_data;
  logic             out_valid;
  logic             out_stall;
  logic [VAL_W-1:0] out_prime;
  logic             out_has_prime;
  logic             out_last;
  logic             out_error;

  // Own copy of the table, its status and the registers
  logic [15:0]      spf_tab [0:65535];
  bit               tab_ready;
  int               tab_limit;
  int               lim_reg;
  int               above_reg;

  query_t           pending_items[$];
  factor_res_t      want_results[$];
  int               fails;
  int               stuck;
  int               idle_max;
  int               in_gap;
  int               out_hold;
  bit               in_took;
  bit               out_took;
  bit               finishing;

  spf_sieve_factorizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_value(in_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_prime(out_prime),
    .out_has_prime(out_has_prime), .out_last(out_last), .out_error(out_error)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Append one expected result
  function automatic void queue_result(factor_res_t r);
    want_results.insert(want_results.size(), r);
  endfunction

  // Sieve up to the saturated limit, smallest prime factor per entry
  function automatic void build_spf_table();
    int    lim;
    int    x;
    longint y;
    lim = lim_reg;
    if (lim < 2) lim = 2;
    if (lim > 65535) lim = 65535;
    for (x = 0; x < 65536; x++) spf_tab[x] = '0;
    for (x = 2; x <= lim; x++) begin
      if (spf_tab[x] != 0) continue;
      spf_tab[x] = x[15:0];
      for (y = longint'(x) * x; y <= lim; y += x) begin
        if (spf_tab[y] == 0) spf_tab[y] = x[15:0];
      end
    end
    tab_limit = lim;
    tab_ready = 1'b1;
  endfunction

  // Work out the results of one accepted item
  function automatic void predict_factors(logic kind, logic [VAL_W-1:0] value);
    int v;
    int p;
    int n;
    int k;
    int found[6];
    n = 0;
    v = value;
    if (kind == KIND_BUILD) begin
      build_spf_table();
      queue_result('{16'd0, 1'b0, 1'b1, 1'b0});
      return;
    end
    if (!tab_ready || v > tab_limit) begin
      queue_result('{16'd0, 1'b0, 1'b1, 1'b1});
      return;
    end
    while (v > 1) begin
      p = spf_tab[v];
      if (p < 2) p = v;
      if (p > above_reg && n < 6) begin
        found[n] = p;
        n++;
      end
      do v = v / p; while (v > 1 && v % p == 0);
    end
    if (n == 0) begin
      queue_result('{16'd0, 1'b0, 1'b1, 1'b0});
      return;
    end
    for (k = 0; k < n; k++)
      queue_result('{found[k][15:0], 1'b1, k == n - 1, 1'b0});
  endfunction

  // Predict on input handshakes, check on output handshakes, watch for a hang
  always @(posedge clk) begin
    factor_res_t got;
    factor_res_t exp_r;
    in_took = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        predict_factors(in_kind, in_value);
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        got = '{out_prime, out_has_prime, out_last, out_error};
        if (want_results.size() == 0) begin
          $display("%0t: unexpected result prime=%0d has=%0d last=%0d err=%0d", $time,
                   got.prime, got.has_prime, got.last, got.error);
          fails++;
        end else begin
          exp_r = want_results.pop_front();
          if (got.prime !== exp_r.prime) begin
            $display("%0t: prime expected %0d got %0d", $time, exp_r.prime, got.prime);
            fails++;
          end
          if (got.has_prime !== exp_r.has_prime) begin
            $display("%0t: has_prime expected %0d got %0d", $time, exp_r.has_prime,
                     got.has_prime);
            fails++;
          end
          if (got.last !== exp_r.last) begin
            $display("%0t: last expected %0d got %0d", $time, exp_r.last, got.last);
            fails++;
          end
          if (got.error !== exp_r.error) begin
            $display("%0t: error expected %0d got %0d", $time, exp_r.error, got.error);
            fails++;
          end
        end
      end
      if (in_took || out_took || finishing) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("tb_spf_sieve_factorizer_core NOT OK");
        $finish;
      end
    end
  end

  // Driver: hold the item until taken, then wait a drawn gap before the next
  always @(negedge clk) begin
    logic   nv;
    query_t q;
    if (rst_n) begin
      nv = in_valid;
      if (in_took) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (pending_items.size() != 0) begin
          q = pending_items.pop_front();
          in_kind <= q.kind;
          in_value <= q.value;
          nv = 1'b1;
          in_gap = $urandom_range(0, idle_max);
        end
      end
      in_valid <= nv;
    end
  end

  // Result side: stall for a drawn gap after each result taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) out_hold = $urandom_range(0, idle_max);
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  task automatic push_item(logic kind, int value);
    query_t q;
    q = '{kind, value[15:0]};
    pending_items.insert(pending_items.size(), q);
  endtask

  // Wait until every item is taken and every result has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || in_valid || want_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data[15:0];
    if (idx == CFG_SIEVE_LIMIT) lim_reg = data;
    else above_reg = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int ph;
    int i;
    int lim;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_BUILD;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SIEVE_LIMIT;
    cfg_data = '0;
    out_stall = 1'b0;
    fails = 0;
    stuck = 0;
    in_gap = 0;
    out_hold = 0;
    idle_max = 5;
    finishing = 1'b0;
    tab_ready = 1'b0;
    tab_limit = 0;
    lim_reg = 65535;
    above_reg = 3;
    for (i = 0; i < 65536; i++) spf_tab[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: query before build, full build at reset limit, edges of value
    push_item(KIND_FACTOR, 12);
    push_item(KIND_BUILD, 65535);
    push_item(KIND_FACTOR, 65535);
    push_item(KIND_FACTOR, 65521);
    push_item(KIND_FACTOR, 0);
    push_item(KIND_FACTOR, 1);
    push_item(KIND_FACTOR, 30030);
    push_item(KIND_FACTOR, 32768);
    push_item(KIND_FACTOR, 9);
    wait_idle();
    write_cfg(CFG_REPORT_ABOVE, 0);
    push_item(KIND_FACTOR, 30030);
    push_item(KIND_FACTOR, 2);
    push_item(KIND_FACTOR, 65534);
    wait_idle();
    write_cfg(CFG_REPORT_ABOVE, 65535);
    push_item(KIND_FACTOR, 30030);
    push_item(KIND_FACTOR, 65521);
    wait_idle();
    // Limits below two saturate to two
    write_cfg(CFG_SIEVE_LIMIT, 0);
    write_cfg(CFG_REPORT_ABOVE, 1);
    push_item(KIND_BUILD, 0);
    push_item(KIND_FACTOR, 2);
    push_item(KIND_FACTOR, 3);
    wait_idle();
    write_cfg(CFG_SIEVE_LIMIT, 1);
    push_item(KIND_BUILD, 40000);
    push_item(KIND_FACTOR, 2);
    push_item(KIND_FACTOR, 65535);
    wait_idle();

    // Random phases: new settings, usually a rebuild, then a burst of queries
    for (ph = 0; ph < 14; ph++) begin
      idle_max = (ph % 4 == 3) ? 0 : 5;
      r = $urandom_range(0, 9);
      lim = (r == 0) ? $urandom_range(0, 1) : $urandom_range(2, 2000);
      write_cfg(CFG_SIEVE_LIMIT, lim);
      r = $urandom_range(0, 7);
      case (r)
        0: write_cfg(CFG_REPORT_ABOVE, 0);
        1: write_cfg(CFG_REPORT_ABOVE, 65535);
        2: write_cfg(CFG_REPORT_ABOVE, $urandom_range(0, 65535));
        3, 4: write_cfg(CFG_REPORT_ABOVE, $urandom_range(0, 3));
        default: write_cfg(CFG_REPORT_ABOVE, $urandom_range(4, 40));
      endcase
      if ($urandom_range(0, 9) != 0) push_item(KIND_BUILD, $urandom_range(0, 65535));
      if (lim < 2) lim = 2;
      for (i = 0; i < 25; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) push_item(KIND_BUILD, $urandom_range(0, 65535));
        else if (r < 3) push_item(KIND_FACTOR, $urandom_range(0, 65535));
        else if (r < 4) push_item(KIND_FACTOR, $urandom_range(0, 1));
        else push_item(KIND_FACTOR, $urandom_range(0, lim));
      end
      wait_idle();
    end

    finishing = 1'b1;
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("tb_spf_sieve_factorizer_core OK");
    end else begin
      $display("tb_spf_sieve_factorizer_core NOT OK");
    end
    $finish;
  end

endmodule
